>>> hdl/rsr_pkg.sv
// rsr_pkg: shared types, constants and the quarter-wave sine table of the
// radial sine ripple shader. no dependencies.
`default_nettype none

package rsr_pkg;

	localparam int ROWS            = 600;
	localparam int SINE_TABLE_BITS = 10;

	localparam int COORD_W  = 10;
	localparam int PHASE_W  = 16;
	localparam int COLOR_W  = 8;
	localparam int SQ_W     = 21;
	localparam int RAD_W    = 32;
	localparam int ROOT_W   = 16;
	localparam int REM_W    = 18;
	localparam int K_W      = 13;
	localparam int AMP_W    = 7;
	localparam int QSINE_W  = 17;
	localparam int UNIT_W   = 18;
	localparam int SHADE_W  = UNIT_W + AMP_W;

	localparam int ISQ_STEPS  = 2;
	localparam int ISQ_STAGES = ROOT_W / ISQ_STEPS;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	localparam logic [K_W-1:0] K_FIFTY  = K_W'(3338);
	localparam logic [K_W-1:0] K_THIRTY = K_W'(5563);

	localparam logic [AMP_W-1:0]   AMP_GREY  = AMP_W'(55);
	localparam logic [AMP_W-1:0]   AMP_BAND  = AMP_W'(75);
	localparam logic [COLOR_W-1:0] GREY_BASE = COLOR_W'(200);
	localparam logic [COLOR_W-1:0] FULL_BLUE = COLOR_W'(255);
	localparam logic [UNIT_W-1:0]  SINE_ONE  = UNIT_W'(65536);

	localparam logic [PHASE_W-1:0] RST_PHASE_STEP = PHASE_W'(1043);
	localparam logic [COORD_W-1:0] RST_CENTER_ROW = COORD_W'(ROWS / 2);
	localparam logic [COORD_W-1:0] RST_BAND1_TOP  = COORD_W'(50);
	localparam logic [COORD_W-1:0] RST_BAND1_BOT  = COORD_W'(120);
	localparam logic [COORD_W-1:0] RST_BAND2_TOP  = COORD_W'(480);
	localparam logic [COORD_W-1:0] RST_BAND2_BOT  = COORD_W'(550);

	typedef enum logic [2:0] {
		REG_PHASE_STEP = 3'd0,
		REG_CENTER_ROW = 3'd1,
		REG_BAND1_TOP  = 3'd2,
		REG_BAND1_BOT  = 3'd3,
		REG_BAND2_TOP  = 3'd4,
		REG_BAND2_BOT  = 3'd5
	} reg_idx_t;

	// per-pixel control that rides along the pipeline
	typedef struct packed {
		logic               band;
		logic [PHASE_W-1:0] phase;
	} side_t;

	localparam int QBITS  = SINE_TABLE_BITS - 2;
	localparam int QDEPTH = 1 << QBITS;

	typedef logic [QSINE_W-1:0] qsine_tab_t [QDEPTH];

	// entry k-1 holds the quarter wave at x = k/QDEPTH, k = 1..QDEPTH
	function automatic qsine_tab_t qsine_build();
		qsine_tab_t  tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		for (int k = 1; k <= QDEPTH; k++) begin
			x  = 64'(k) << (16 - QBITS);
			x2 = (x * x) >> 16;
			t  = 64'd5223 - ((x2 * 64'd307) >> 16);
			t  = 64'd42334 - ((x2 * t) >> 16);
			t  = 64'd102944 - ((x2 * t) >> 16);
			t  = (x * t) >> 16;
			if (t > 64'd65536)
				t = 64'd65536;
			tab[k-1] = t[QSINE_W-1:0];
		end
		return tab;
	endfunction

	localparam qsine_tab_t QSINE_TAB = qsine_build();

endpackage

`default_nettype wire

>>> hdl/rsr_geom.sv
// rsr_geom: row offset, band test and squared distance, three stages.
// depends on rsr_pkg.
`default_nettype none

module rsr_geom (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          vld_in,
	input  wire logic [rsr_pkg::COORD_W-1:0]   row,
	input  wire logic [rsr_pkg::COORD_W-1:0]   column,
	input  wire logic [rsr_pkg::PHASE_W-1:0]   phase,
	input  wire logic [rsr_pkg::COORD_W-1:0]   center_row,
	input  wire logic [rsr_pkg::COORD_W-1:0]   band1_top,
	input  wire logic [rsr_pkg::COORD_W-1:0]   band1_bot,
	input  wire logic [rsr_pkg::COORD_W-1:0]   band2_top,
	input  wire logic [rsr_pkg::COORD_W-1:0]   band2_bot,
	output      logic                          vld_out,
	output      logic [rsr_pkg::SQ_W-1:0]      sq,
	output      rsr_pkg::side_t                side_out
);

	localparam int PROD_W = 2 * rsr_pkg::COORD_W;

	logic                          vld_s1, vld_s2, vld_s3;
	logic [rsr_pkg::COORD_W-1:0]   dr_s1, col_s1;
	logic [PROD_W-1:0]             dr2_s2, col2_s2;
	logic [rsr_pkg::SQ_W-1:0]      sq_s3;
	rsr_pkg::side_t                side_s1, side_s2, side_s3;
	logic [rsr_pkg::COORD_W-1:0]   dr;
	logic                          in_band;

	always_comb begin
		dr = (row >= center_row) ? row - center_row : center_row - row;
		in_band = (row >= band1_top && row <= band1_bot) ||
			(row >= band2_top && row <= band2_bot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dr_s1         <= dr;
			col_s1        <= column;
			side_s1.band  <= in_band;
			side_s1.phase <= phase;
			dr2_s2        <= PROD_W'(dr_s1) * PROD_W'(dr_s1);
			col2_s2       <= PROD_W'(col_s1) * PROD_W'(col_s1);
			side_s2       <= side_s1;
			sq_s3         <= rsr_pkg::SQ_W'(dr2_s2) + rsr_pkg::SQ_W'(col2_s2);
			side_s3       <= side_s2;
		end
	end

	assign vld_out  = vld_s3;
	assign sq       = sq_s3;
	assign side_out = side_s3;

endmodule

`default_nettype wire

>>> hdl/rsr_isqrt.sv
// rsr_isqrt: pipelined restoring integer square root, two root bits a stage.
// depends on rsr_pkg.
`default_nettype none

module rsr_isqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          vld_in,
	input  wire logic [rsr_pkg::RAD_W-1:0]     rad,
	input  wire rsr_pkg::side_t                side_in,
	output      logic                          vld_out,
	output      logic [rsr_pkg::ROOT_W-1:0]    root,
	output      rsr_pkg::side_t                side_out
);

	localparam int NST  = rsr_pkg::ISQ_STAGES;
	localparam int LAST = NST - 1;
	localparam int CW   = rsr_pkg::REM_W + 2;

	logic                          vld_s  [NST];
	logic [rsr_pkg::RAD_W-1:0]     rad_s  [NST];
	logic [rsr_pkg::REM_W-1:0]     rem_s  [NST];
	logic [rsr_pkg::ROOT_W-1:0]    root_s [NST];
	rsr_pkg::side_t                side_s [NST];

	for (genvar g = 0; g < NST; g++) begin : g_stage
		logic                          v_i;
		logic [rsr_pkg::RAD_W-1:0]     rad_i;
		logic [rsr_pkg::REM_W-1:0]     rem_i;
		logic [rsr_pkg::ROOT_W-1:0]    root_i;
		rsr_pkg::side_t                side_i;
		logic [rsr_pkg::RAD_W-1:0]     rad_c;
		logic [rsr_pkg::REM_W-1:0]     rem_c;
		logic [rsr_pkg::ROOT_W-1:0]    root_c;
		logic [CW-1:0]                 cand;
		logic [CW-1:0]                 trial;

		if (g == 0) begin : g_first
			assign v_i    = vld_in;
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = vld_s[g-1];
			assign rad_i  = rad_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign root_i = root_s[g-1];
			assign side_i = side_s[g-1];
		end

		always_comb begin
			rad_c  = rad_i;
			rem_c  = rem_i;
			root_c = root_i;
			cand   = '0;
			trial  = '0;
			for (int i = 0; i < rsr_pkg::ISQ_STEPS; i++) begin
				cand  = {rem_c, rad_c[rsr_pkg::RAD_W-1 -: 2]};
				trial = CW'({root_c, 2'b01});
				if (cand >= trial) begin
					rem_c  = rsr_pkg::REM_W'(cand - trial);
					root_c = {root_c[rsr_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_c  = cand[rsr_pkg::REM_W-1:0];
					root_c = {root_c[rsr_pkg::ROOT_W-2:0], 1'b0};
				end
				rad_c = {rad_c[rsr_pkg::RAD_W-3:0], 2'b00};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[g] <= 1'b0;
			else if (adv)
				vld_s[g] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[g]  <= rad_c;
				rem_s[g]  <= rem_c;
				root_s[g] <= root_c;
				side_s[g] <= side_i;
			end
		end
	end

	assign vld_out  = vld_s[LAST];
	assign root     = root_s[LAST];
	assign side_out = side_s[LAST];

	// remainder of a floor root never exceeds twice the root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAST] |-> rem_s[LAST] <= rsr_pkg::REM_W'({root_s[LAST], 1'b0}))
		else $error("isqrt remainder out of range");

endmodule

`default_nettype wire

>>> hdl/rsr_wave.sv
// rsr_wave: angle, sine table lookup and shading, five stages; the last
// stage is the output register. depends on rsr_pkg.
`default_nettype none

module rsr_wave (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          vld_in,
	input  wire logic [rsr_pkg::ROOT_W-1:0]    root,
	input  wire rsr_pkg::side_t                side_in,
	output      logic                          vld_out,
	output      logic [rsr_pkg::COLOR_W-1:0]   red,
	output      logic [rsr_pkg::COLOR_W-1:0]   blue
);

	localparam int MUL_W = rsr_pkg::ROOT_W + rsr_pkg::K_W;
	localparam int QB    = rsr_pkg::QBITS;
	localparam int STB   = rsr_pkg::SINE_TABLE_BITS;

	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	rsr_pkg::side_t                side_s1, side_s2;
	logic                          band_s3, band_s4;
	logic [rsr_pkg::PHASE_W-1:0]   radial_s1, ang_s2;
	logic [rsr_pkg::QSINE_W-1:0]   mag_s3;
	logic                          neg_s3;
	logic [rsr_pkg::SHADE_W-1:0]   prod_s4;
	logic [rsr_pkg::COLOR_W-1:0]   red_s5, blue_s5;

	logic [MUL_W-1:0]              radial;
	logic [STB-1:0]                idx;
	logic [QB:0]                   k;
	logic [rsr_pkg::QSINE_W-1:0]   mag;
	logic [rsr_pkg::UNIT_W-1:0]    unit;
	logic [rsr_pkg::COLOR_W-1:0]   shade;

	always_comb begin
		radial = MUL_W'(root) *
			MUL_W'(side_in.band ? rsr_pkg::K_THIRTY : rsr_pkg::K_FIFTY);
		idx = ang_s2[rsr_pkg::PHASE_W-1 -: STB];
		// odd quadrants run the quarter wave backwards
		if (idx[STB-2])
			k = (QB+1)'(rsr_pkg::QDEPTH) - {1'b0, idx[QB-1:0]};
		else
			k = {1'b0, idx[QB-1:0]};
		if (k == '0)
			mag = '0;
		else
			mag = rsr_pkg::QSINE_TAB[QB'(k - 1'b1)];
		unit = neg_s3 ? rsr_pkg::SINE_ONE - rsr_pkg::UNIT_W'(mag_s3)
			: rsr_pkg::SINE_ONE + rsr_pkg::UNIT_W'(mag_s3);
		shade = prod_s4[rsr_pkg::SHADE_W-1 -: rsr_pkg::COLOR_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			radial_s1 <= radial[8 +: rsr_pkg::PHASE_W];
			side_s1   <= side_in;
			ang_s2    <= radial_s1 + side_s1.phase;
			side_s2   <= side_s1;
			mag_s3    <= mag;
			neg_s3    <= idx[STB-1];
			band_s3   <= side_s2.band;
			prod_s4   <= rsr_pkg::SHADE_W'(unit) * rsr_pkg::SHADE_W'(
				band_s3 ? rsr_pkg::AMP_BAND : rsr_pkg::AMP_GREY);
			band_s4   <= band_s3;
			if (band_s4) begin
				red_s5  <= shade;
				blue_s5 <= rsr_pkg::FULL_BLUE;
			end else begin
				red_s5  <= rsr_pkg::GREY_BASE + shade;
				blue_s5 <= rsr_pkg::GREY_BASE + shade;
			end
		end
	end

	assign vld_out = vld_s5;
	assign red     = red_s5;
	assign blue    = blue_s5;

endmodule

`default_nettype wire

>>> hdl/radial_sine_ripple_shader.sv
// radial_sine_ripple_shader: top level with input skid stage, phase
// accumulator, register port and the geom / isqrt / wave pipeline.
// depends on rsr_pkg, rsr_geom, rsr_isqrt, rsr_wave.
//
//   channel   dir   handshake                   payload
//   s_axis    in    s_axis_tvalid/tready         row, column, new_frame
//   m_axis    out   m_axis_tvalid/tready         red, green, blue
//   apb       in    psel/penable/pwrite/pready   six config registers
//
// one pixel per clock sustained while m_axis is not stalled; the pipeline is
// the eight-stage square root plus three geometry and five shading stages.
// the phase steps back when a new_frame request enters the pipeline.
// reset clears all valid bits and loads the register defaults, phase zero.
// a stall on m_axis freezes every stage; the skid register keeps one request
// so s_axis_tready comes from a flop.
`default_nettype none

module radial_sine_ripple_shader (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output      logic                             s_axis_tready,
	// row [9:0], column [19:10], zero [23:20]
	input  wire logic [23:0]                      s_axis_tdata,
	// new_frame [0]
	input  wire logic [0:0]                       s_axis_tuser,
	output      logic                             m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// red [7:0], green [15:8], blue [23:16]
	output      logic [23:0]                      m_axis_tdata,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [rsr_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [rsr_pkg::CFG_DATA_W-1:0]   pwdata,
	output      logic [rsr_pkg::CFG_DATA_W-1:0]   prdata,
	output      logic                             pready
);

	localparam int CW = rsr_pkg::COORD_W;
	localparam int DW = rsr_pkg::CFG_DATA_W;

	logic [rsr_pkg::PHASE_W-1:0] phase_step_q, phase_q, phase_next;
	logic [CW-1:0]               center_row_q, band1_top_q, band1_bot_q;
	logic [CW-1:0]               band2_top_q, band2_bot_q;
	rsr_pkg::reg_idx_t           reg_sel;
	logic                        cfg_wr;

	logic                        skid_vld_q, skid_frame_q;
	logic [CW-1:0]               skid_row_q, skid_col_q;
	logic                        pipe_vld, pipe_frame, entry, adv;
	logic [CW-1:0]               pipe_row, pipe_col;

	logic                        geo_vld, isq_vld, wave_vld;
	logic [rsr_pkg::SQ_W-1:0]    geo_sq;
	rsr_pkg::side_t              geo_side, isq_side;
	logic [rsr_pkg::ROOT_W-1:0]  isq_root;
	logic [rsr_pkg::COLOR_W-1:0] wave_red, wave_blue;

	// register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_sel = rsr_pkg::reg_idx_t'(paddr[rsr_pkg::CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= rsr_pkg::RST_PHASE_STEP;
			center_row_q <= rsr_pkg::RST_CENTER_ROW;
			band1_top_q  <= rsr_pkg::RST_BAND1_TOP;
			band1_bot_q  <= rsr_pkg::RST_BAND1_BOT;
			band2_top_q  <= rsr_pkg::RST_BAND2_TOP;
			band2_bot_q  <= rsr_pkg::RST_BAND2_BOT;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				rsr_pkg::REG_PHASE_STEP: phase_step_q <= pwdata[rsr_pkg::PHASE_W-1:0];
				rsr_pkg::REG_CENTER_ROW: center_row_q <= pwdata[CW-1:0];
				rsr_pkg::REG_BAND1_TOP:  band1_top_q  <= pwdata[CW-1:0];
				rsr_pkg::REG_BAND1_BOT:  band1_bot_q  <= pwdata[CW-1:0];
				rsr_pkg::REG_BAND2_TOP:  band2_top_q  <= pwdata[CW-1:0];
				rsr_pkg::REG_BAND2_BOT:  band2_bot_q  <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			rsr_pkg::REG_PHASE_STEP: prdata = DW'(phase_step_q);
			rsr_pkg::REG_CENTER_ROW: prdata = DW'(center_row_q);
			rsr_pkg::REG_BAND1_TOP:  prdata = DW'(band1_top_q);
			rsr_pkg::REG_BAND1_BOT:  prdata = DW'(band1_bot_q);
			rsr_pkg::REG_BAND2_TOP:  prdata = DW'(band2_top_q);
			rsr_pkg::REG_BAND2_BOT:  prdata = DW'(band2_bot_q);
			default:                 prdata = '0;
		endcase
	end

	// input skid and pipeline entry
	assign adv           = ~wave_vld | m_axis_tready;
	assign s_axis_tready = ~skid_vld_q;
	assign pipe_vld      = skid_vld_q | s_axis_tvalid;
	assign pipe_row      = skid_vld_q ? skid_row_q : s_axis_tdata[CW-1:0];
	assign pipe_col      = skid_vld_q ? skid_col_q : s_axis_tdata[2*CW-1:CW];
	assign pipe_frame    = skid_vld_q ? skid_frame_q : s_axis_tuser[0];
	assign entry         = adv & pipe_vld;
	assign phase_next    = pipe_frame ? phase_q - phase_step_q : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
			phase_q    <= '0;
		end else begin
			if (adv)
				skid_vld_q <= 1'b0;
			else if (s_axis_tvalid & s_axis_tready)
				skid_vld_q <= 1'b1;
			if (entry)
				phase_q <= phase_next;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && s_axis_tvalid && s_axis_tready) begin
			skid_row_q   <= s_axis_tdata[CW-1:0];
			skid_col_q   <= s_axis_tdata[2*CW-1:CW];
			skid_frame_q <= s_axis_tuser[0];
		end
	end

	rsr_geom u_geom (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.vld_in     (pipe_vld),
		.row        (pipe_row),
		.column     (pipe_col),
		.phase      (phase_next),
		.center_row (center_row_q),
		.band1_top  (band1_top_q),
		.band1_bot  (band1_bot_q),
		.band2_top  (band2_top_q),
		.band2_bot  (band2_bot_q),
		.vld_out    (geo_vld),
		.sq         (geo_sq),
		.side_out   (geo_side)
	);

	rsr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_in   (geo_vld),
		.rad      ({3'b000, geo_sq, 8'h00}),
		.side_in  (geo_side),
		.vld_out  (isq_vld),
		.root     (isq_root),
		.side_out (isq_side)
	);

	rsr_wave u_wave (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_in  (isq_vld),
		.root    (isq_root),
		.side_in (isq_side),
		.vld_out (wave_vld),
		.red     (wave_red),
		.blue    (wave_blue)
	);

	assign m_axis_tvalid = wave_vld;
	assign m_axis_tdata  = {wave_blue, wave_red, wave_red};

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(!adv))
		else $error("skid filled without a stall");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(entry && pipe_frame) |=> $stable(phase_q))
		else $error("phase moved without a new frame request");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && adv) |=> !skid_vld_q)
		else $error("skid request not taken on advance");

endmodule

`default_nettype wire
